/* sv/pli_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   // Widths of the fixed-size fields of the request and the configuration register.
   localparam int ENTRY_INDEX_WIDTH = 6;
   localparam int POINT_COUNT_WIDTH = 7;

   // Request command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [POINT_COUNT_WIDTH-1:0] POINT_COUNT_RESET = POINT_COUNT_WIDTH'(2);

   // Sequencer of the search and output hand-off.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_PROBE,
      ST_READ_LO,
      ST_READ_HI,
      ST_ARITH,
      ST_OUT
   } pli_state_type;

   // Phases of the shared multiply and divide unit.
   typedef enum logic [2:0] {
      AR_IDLE,
      AR_MUL,
      AR_PREP,
      AR_DIV,
      AR_FIN
   } pli_arith_phase_type;

endpackage

`default_nettype wire

/* sv/piecewise_linear_interp.sv */
`timescale 1ns / 1ps
`default_nettype none

// Piecewise linear interpolation over a table of up to MAX_POINTS breakpoints, each an
// abscissa and an ordinate in signed fixed point of DATA_WIDTH bits. A request with cmd
// 0 writes one table entry and produces no response; an index at or
// beyond MAX_POINTS is dropped. A request with cmd 1 is a query and produces exactly one
// response. The register point_count selects how many leading entries are in use; values
// below 2 act as 2 and values above MAX_POINTS act as MAX_POINTS. Queries at or below the
// first abscissa return the first ordinate, queries at or above the last return the last.
// Otherwise a bisection search runs over the table memory, one registered read per step,
// and either hits an exact breakpoint or finds the bracketing pair, whose ordinates are
// blended by one shared shift-add multiplier and a restoring divider that truncates
// toward zero. Multiplication and division each handle one bit per step. While a
// query is in work req_stall stays high; a finished response waits in the output
// register, and new requests are taken while it waits. Table entries must be written
// before they are read. The user must write point_count only while no query is in
// work; the block itself does not enforce it.

module piecewise_linear_interp
   import pli_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_cmd,
   input  wire logic        [ENTRY_INDEX_WIDTH-1:0] req_entry_index,
   input  wire logic signed [DATA_WIDTH-1:0]        req_breakpoint_x,
   input  wire logic signed [DATA_WIDTH-1:0]        req_breakpoint_value,
   input  wire logic signed [DATA_WIDTH-1:0]        req_query_x,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [DATA_WIDTH-1:0]        rsp_interp_value,

   input  wire logic                                csr_we,
   input  wire logic        [POINT_COUNT_WIDTH-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_POINTS);
   // Width wide enough for both the point count and MAX_POINTS itself.
   localparam int NW = (AW + 1 > POINT_COUNT_WIDTH) ? AW + 1 : POINT_COUNT_WIDTH;
   // Width wide enough for both the entry index and MAX_POINTS itself.
   localparam int EW = (AW + 1 > ENTRY_INDEX_WIDTH) ? AW + 1 : ENTRY_INDEX_WIDTH;

   pli_state_type state_ff, state_in;

   logic [POINT_COUNT_WIDTH-1:0] point_count_ff;

   logic signed [DATA_WIDTH-1:0] q_ff, q_in;
   logic        [AW-1:0]         lo_ff, lo_in;
   logic        [AW-1:0]         hi_ff, hi_in;
   logic        [AW-1:0]         mid_ff, mid_in;
   logic signed [DATA_WIDTH-1:0] xl_ff, xl_in;
   logic signed [DATA_WIDTH-1:0] vl_ff, vl_in;
   logic        [DATA_WIDTH-1:0] dl_ff, dl_in;
   logic signed [DATA_WIDTH-1:0] res_ff, res_in;
   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff;

   // Effective table size and the index of the last entry in use.
   logic [NW-1:0] count_ext;
   logic [NW-1:0] count_eff;
   logic [AW-1:0] last_idx;

   // Table ports.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_x_raw;
   logic [DATA_WIDTH-1:0] rd_v_raw;
   logic signed [DATA_WIDTH-1:0] rd_x;
   logic signed [DATA_WIDTH-1:0] rd_v;

   // Search step.
   logic          x_gt, x_lt;
   logic [AW-1:0] step_lo, step_hi;
   logic [AW-1:0] step_span;
   logic          more_steps;
   logic [AW-1:0] next_mid;
   logic [AW:0]   mid_sum;

   // Shared arithmetic unit.
   logic                         ar_start;
   logic                         ar_done;
   logic signed [DATA_WIDTH-1:0] ar_result;
   logic        [DATA_WIDTH-1:0] dist_hi;
   logic        [DATA_WIDTH-1:0] span;

   logic req_xfer;
   logic rsp_xfer;
   logic out_free;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_ext = NW'(point_count_ff);
      if (count_ext < NW'(2)) begin
         count_eff = NW'(2);
      end else if (count_ext > NW'(MAX_POINTS)) begin
         count_eff = NW'(MAX_POINTS);
      end else begin
         count_eff = count_ext;
      end
      last_idx = AW'(count_eff - NW'(1));
   end

   assign wr_en   = req_xfer && (req_cmd == CMD_WRITE)
                    && (EW'(req_entry_index) < EW'(MAX_POINTS));
   assign wr_addr = AW'(req_entry_index);

   pli_table #(
      .MAX_POINTS (MAX_POINTS),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_x    (req_breakpoint_x),
      .wr_v    (req_breakpoint_value),
      .rd_addr (rd_addr),
      .rd_x_ff (rd_x_raw),
      .rd_v_ff (rd_v_raw)
   );

   assign rd_x = signed'(rd_x_raw);
   assign rd_v = signed'(rd_v_raw);

   // One bisection step: the probed abscissa narrows the bracket, and the next probe
   // is the midpoint of the narrowed bracket while it still spans more than one entry.
   always_comb begin
      x_gt       = rd_x > q_ff;
      x_lt       = rd_x < q_ff;
      step_lo    = ((state_ff == ST_PROBE) && x_lt) ? mid_ff : lo_ff;
      step_hi    = ((state_ff == ST_PROBE) && x_gt) ? mid_ff : hi_ff;
      step_span  = step_hi - step_lo;
      more_steps = step_span > AW'(1);
      mid_sum    = {1'b0, step_lo} + {1'b0, step_hi};
      next_mid   = mid_sum[AW:1];
   end

   // Distances in the bracket are positive and below 2**DATA_WIDTH, so the wrapped
   // differences read as unsigned are exact.
   assign dist_hi = rd_x_raw - q_ff;
   assign span    = rd_x_raw - xl_ff;

   pli_arith #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_arith (
      .clock   (clock),
      .reset   (reset),
      .start   (ar_start),
      .val_lo  (vl_ff),
      .val_hi  (rd_v),
      .dist_lo (dl_ff),
      .dist_hi (dist_hi),
      .span    (span),
      .done    (ar_done),
      .result  (ar_result)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_xfer && (req_cmd == CMD_QUERY)) begin
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            state_in = (q_ff <= rd_x) ? ST_OUT : ST_LAST;
         end
         ST_LAST: begin
            if (q_ff >= rd_x) begin
               state_in = ST_OUT;
            end else begin
               state_in = more_steps ? ST_PROBE : ST_READ_LO;
            end
         end
         ST_PROBE: begin
            if (!x_gt && !x_lt) begin
               state_in = ST_OUT;
            end else begin
               state_in = more_steps ? ST_PROBE : ST_READ_LO;
            end
         end
         ST_READ_LO: state_in = ST_READ_HI;
         ST_READ_HI: state_in = ST_ARITH;
         ST_ARITH: if (ar_done) begin
            state_in = ST_OUT;
         end
         ST_OUT: if (out_free) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath register updates of the sequencer.
   always_comb begin
      q_in     = q_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      xl_in    = xl_ff;
      vl_in    = vl_ff;
      dl_in    = dl_ff;
      res_in   = res_ff;
      rd_addr  = step_lo;
      ar_start = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff) inside
         ST_IDLE: begin
            rd_addr = '0;
            q_in    = req_query_x;
            lo_in   = '0;
            hi_in   = last_idx;
         end
         ST_FIRST: begin
            rd_addr = last_idx;
            res_in  = rd_v;
         end
         ST_LAST, ST_PROBE: begin
            res_in = rd_v;
            lo_in  = step_lo;
            hi_in  = step_hi;
            mid_in = next_mid;
            rd_addr = more_steps ? next_mid : step_lo;
         end
         ST_READ_LO: begin
            rd_addr = hi_ff;
            xl_in   = rd_x;
            vl_in   = rd_v;
            dl_in   = q_ff - rd_x_raw;
         end
         ST_READ_HI: begin
            ar_start = 1'b1;
         end
         ST_ARITH: begin
            if (ar_done) begin
               res_in = ar_result;
            end
         end
         ST_OUT: begin
            res_in = res_ff;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= POINT_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            point_count_ff <= csr_wdata;
         end
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      xl_ff  <= xl_in;
      vl_ff  <= vl_in;
      dl_ff  <= dl_in;
      res_ff <= res_in;
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_value_ff <= res_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;

endmodule

`default_nettype wire

/* sv/pli_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module pli_table
   import pli_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = $clog2(MAX_POINTS)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_x,
   input  wire logic [DATA_WIDTH-1:0] wr_v,
   input  wire logic [AW-1:0]         rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_x_ff,
   output logic      [DATA_WIDTH-1:0] rd_v_ff
);

   // Abscissa and ordinate memories share one write and one read address.
   logic [DATA_WIDTH-1:0] x_mem [MAX_POINTS];
   logic [DATA_WIDTH-1:0] v_mem [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         v_mem[wr_addr] <= wr_v;
      end
   end

   always_ff @(posedge clock) begin
      rd_x_ff <= x_mem[rd_addr];
      rd_v_ff <= v_mem[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/pli_arith.sv */
`timescale 1ns / 1ps
`default_nettype none

module pli_arith
   import pli_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DATA_WIDTH-1:0] val_lo,
   input  wire logic signed [DATA_WIDTH-1:0] val_hi,
   input  wire logic        [DATA_WIDTH-1:0] dist_lo,
   input  wire logic        [DATA_WIDTH-1:0] dist_hi,
   input  wire logic        [DATA_WIDTH-1:0] span,
   output logic                              done,
   output logic signed      [DATA_WIDTH-1:0] result
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);

   pli_arith_phase_type phase_ff, phase_in;

   logic signed [PW-1:0]         acc_ff, acc_in;
   logic signed [PW-1:0]         mr_ff, mr_in;
   logic signed [PW-1:0]         ml_ff, ml_in;
   logic        [DATA_WIDTH-1:0] a_ff, a_in;
   logic        [DATA_WIDTH-1:0] b_ff, b_in;
   logic        [DATA_WIDTH-1:0] den_ff, den_in;
   logic                         neg_ff, neg_in;
   logic        [CW-1:0]         cnt_ff, cnt_in;

   logic                         last_step;
   logic signed [PW-1:0]         add_r, add_l;
   logic        [PW-1:0]         mag;
   logic        [DATA_WIDTH:0]   trial;

   assign last_step = (cnt_ff == '0);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         AR_IDLE: if (start) begin
            phase_in = AR_MUL;
         end
         AR_MUL: if (last_step) begin
            phase_in = AR_PREP;
         end
         AR_PREP: phase_in = AR_DIV;
         AR_DIV: if (last_step) begin
            phase_in = AR_FIN;
         end
         AR_FIN: phase_in = AR_IDLE;
         default: phase_in = AR_IDLE;
      endcase
   end

   // Datapath: shift-add multiply of both products at once, then restoring division.
   always_comb begin
      acc_in = acc_ff;
      mr_in  = mr_ff;
      ml_in  = ml_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      add_r  = a_ff[0] ? mr_ff : '0;
      add_l  = b_ff[0] ? ml_ff : '0;
      mag    = acc_ff[PW-1] ? PW'(-acc_ff) : PW'(acc_ff);
      trial  = {acc_ff[PW-1:DATA_WIDTH], acc_ff[DATA_WIDTH-1]} - {1'b0, den_ff};
      unique case (phase_ff)
         AR_IDLE: begin
            acc_in = '0;
            mr_in  = PW'(val_hi);
            ml_in  = PW'(val_lo);
            a_in   = dist_lo;
            b_in   = dist_hi;
            den_in = span;
            cnt_in = CW'(DATA_WIDTH - 1);
         end
         AR_MUL: begin
            acc_in = acc_ff + add_r + add_l;
            mr_in  = mr_ff <<< 1;
            ml_in  = ml_ff <<< 1;
            a_in   = a_ff >> 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff - CW'(1);
         end
         AR_PREP: begin
            // The magnitude of the numerator, high half as remainder, low half as quotient.
            neg_in = acc_ff[PW-1];
            acc_in = signed'(mag);
            cnt_in = CW'(DATA_WIDTH - 1);
         end
         AR_DIV: begin
            if (!trial[DATA_WIDTH]) begin
               acc_in = signed'({trial[DATA_WIDTH-1:0], acc_ff[DATA_WIDTH-2:0], 1'b1});
            end else begin
               acc_in = acc_ff <<< 1;
            end
            cnt_in = cnt_ff - CW'(1);
         end
         AR_FIN: begin
            acc_in = acc_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      done   = (phase_ff == AR_FIN);
      result = neg_ff ? DATA_WIDTH'(-acc_ff[DATA_WIDTH-1:0])
                      : signed'(acc_ff[DATA_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= AR_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mr_ff  <= mr_in;
      ml_ff  <= ml_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

/* test/tb_piecewise_linear_interp.sv */
`timescale 1ns / 1ps

import pli_pkg::*;

localparam int TABLE_DEPTH = 64;

// Mirror of the breakpoint table and the point count. It predicts the value
// of every query at the moment the query is taken, and compares each returned
// value with the oldest pending prediction.
class interp_mirror;
   logic signed [31:0]           abscissa [TABLE_DEPTH];
   logic signed [31:0]           ordinate [TABLE_DEPTH];
   logic [POINT_COUNT_WIDTH-1:0] point_count;
   logic signed [31:0]           pending_values [$];
   int                           mismatch_count;

   function new();
      point_count    = POINT_COUNT_RESET;
      mismatch_count = 0;
   endfunction

   // Out-of-range counts act as the nearest legal count.
   function int effective_count();
      if (point_count < 2) return 2;
      if (point_count > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(point_count);
   endfunction

   function logic signed [31:0] interpolate_at(logic signed [31:0] query);
      int     n, lo, hi, mid;
      longint q, xm, xl, xr, num, den;
      n  = effective_count();
      lo = 0;
      hi = n - 1;
      q  = query;
      xl = abscissa[0];
      xr = abscissa[n-1];
      if (q <= xl) return ordinate[0];
      if (q >= xr) return ordinate[n-1];
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         xm  = abscissa[mid];
         if (xm > q) hi = mid;
         else if (xm < q) lo = mid;
         else return ordinate[mid];
      end
      xl  = abscissa[lo];
      xr  = abscissa[hi];
      den = xr - xl;
      num = longint'(ordinate[hi]) * (q - xl) + longint'(ordinate[lo]) * (xr - q);
      // SystemVerilog signed division truncates toward zero, as the block does.
      return 32'(num / den);
   endfunction

   function void note_request(logic cmd, logic [ENTRY_INDEX_WIDTH-1:0] index,
                              logic signed [31:0] bx, logic signed [31:0] bv,
                              logic signed [31:0] qx);
      if (cmd == CMD_WRITE) begin
         abscissa[index] = bx;
         ordinate[index] = bv;
      end else begin
         pending_values.push_back(interpolate_at(qx));
      end
   endfunction

   task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task check_response(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending_values.size() == 0) begin
         report_mismatch($sformatf("interp_value %0d arrived with no query pending", got));
      end else begin
         want = pending_values.pop_front();
         if (got !== want)
            report_mismatch($sformatf("interp_value %0d, predicted %0d", got, want));
      end
   endtask
endclass

module tb_piecewise_linear_interp;

   // The slowest legal run is far below this: about 1200 items, each with at most a
   // long sender gap, the search and arithmetic of a query, and a long
   // receiver stall.
   localparam int CYCLE_LIMIT = 1_500_000;
   // Quiet cycles that cover anything still in flight inside the block,
   // including a query that interpolates.
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 1150;

   localparam longint X_MIN = -(longint'(1) << 31);
   localparam longint X_MAX = (longint'(1) << 31) - 1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_cmd = CMD_WRITE;
   logic [ENTRY_INDEX_WIDTH-1:0]  req_entry_index = '0;
   logic signed [31:0]            req_breakpoint_x = '0;
   logic signed [31:0]            req_breakpoint_value = '0;
   logic signed [31:0]            req_query_x = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [31:0]            rsp_interp_value;
   logic                          csr_we = 1'b0;
   logic [POINT_COUNT_WIDTH-1:0]  csr_wdata = '0;

   interp_mirror mirror = new();

   int cycle_count = 0;
   int items_sent = 0;
   // Sender pacing: 0 sends back to back, 1 has mostly short gaps, 2 has
   // frequent and sometimes long gaps.
   int pace_mode = 0;
   // Receiver pacing works the same way but changes on its own schedule.
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;

   piecewise_linear_interp #(
      .MAX_POINTS(64),
      .DATA_WIDTH(32)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_entry_index      (req_entry_index),
      .req_breakpoint_x     (req_breakpoint_x),
      .req_breakpoint_value (req_breakpoint_value),
      .req_query_x          (req_query_x),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_interp_value     (rsp_interp_value),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata)
   );

   always #6 clock = ~clock;

   // Both channels are watched from one process so that the request transfer
   // is always noted before any response transfer of the same edge. Values are
   // read in the active region, before any flop of this edge has updated.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            mirror.note_request(req_cmd, req_entry_index, req_breakpoint_x,
                                req_breakpoint_value, req_query_x);
         if (rsp_valid && !rsp_stall)
            mirror.check_response(rsp_interp_value);
      end
   end

   // Watchdog for a hung block or a lost response.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver back-pressure. The mode is picked anew at random, so the
   // run has stretches with no stalls, stretches of short stalls, and stretches
   // where long stalls hold a finished value in the output register.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(100, 800);
      end else begin
         mode_left--;
      end
      if (hold_left != 0) begin
         hold_left--;
      end else begin
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
               hold_left = $urandom_range(0, 20);
            end
            1: begin
               if ($urandom_range(0, 99) < 30) begin
                  rsp_stall <= 1'b1;
                  hold_left = $urandom_range(0, 2);
               end else begin
                  rsp_stall <= 1'b0;
                  hold_left = $urandom_range(0, 4);
               end
            end
            default: begin
               if ($urandom_range(0, 99) < 20) begin
                  rsp_stall <= 1'b1;
                  hold_left = $urandom_range(10, 60);
               end else begin
                  rsp_stall <= 1'b0;
                  hold_left = $urandom_range(0, 9);
               end
            end
         endcase
      end
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      case (pace_mode)
         0: return 0;
         1: begin
            if (r < 70) return 0;
            if (r < 95) return $urandom_range(1, 3);
            return $urandom_range(10, 40);
         end
         default: begin
            if (r < 40) return 0;
            if (r < 85) return $urandom_range(1, 4);
            return $urandom_range(8, 60);
         end
      endcase
   endfunction

   // Uniform pick in [lo, hi]; the span may reach 2**32.
   function automatic longint pick_between(longint lo, longint hi);
      logic [63:0] r;
      longint      span;
      span = hi - lo + 1;
      r    = {$urandom, $urandom};
      return lo + longint'(r % 64'(span));
   endfunction

   function automatic logic signed [31:0] pick_ordinate();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'($urandom_range(0, 2000)) - 32'sd1000;
         default: return $urandom;
      endcase
   endfunction

   // Queries are aimed mostly at the interesting places of the current table:
   // exact breakpoints, the inside of a bracketing pair, one step off a
   // breakpoint, and the two ends of the number range.
   function automatic logic signed [31:0] make_query(int n);
      int                 i;
      logic signed [31:0] a, b;
      i = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
         0, 1, 2: return mirror.abscissa[i];
         3, 4, 5: begin
            i = $urandom_range(0, n - 2);
            a = mirror.abscissa[i];
            b = mirror.abscissa[i+1];
            if (a < b) return 32'(pick_between(a, b));
            return $urandom;
         end
         6: return mirror.abscissa[i] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
         7: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // One request transfer. Valid is only dropped when a gap is wanted, so it
   // stays high without a glitch between back-to-back items. The payload holds
   // until the edge at which stall is seen low.
   task automatic send_item(logic cmd, logic [ENTRY_INDEX_WIDTH-1:0] index,
                            logic signed [31:0] bx, logic signed [31:0] bv,
                            logic signed [31:0] qx);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_cmd              <= cmd;
      req_entry_index      <= index;
      req_breakpoint_x     <= bx;
      req_breakpoint_value <= bv;
      req_query_x          <= qx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // The fields that a command does not use carry random noise.
   task automatic write_entry(logic [ENTRY_INDEX_WIDTH-1:0] index, logic signed [31:0] bx,
                              logic signed [31:0] bv);
      send_item(CMD_WRITE, index, bx, bv, $urandom);
   endtask

   task automatic ask(logic signed [31:0] qx);
      send_item(CMD_QUERY, 6'($urandom), $urandom, $urandom, qx);
   endtask

   // Stop sending, let every pending query come back, then give the block
   // enough quiet cycles to finish anything that has no response.
   task automatic drain_idle();
      req_valid <= 1'b0;
      while (mirror.pending_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_point_count(logic [POINT_COUNT_WIDTH-1:0] value);
      drain_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.point_count = value;
   endtask

   // Fills entries 0..n-1 so that no query can read an unwritten entry. Most
   // tables are ascending with a random spacing scale (steps of zero give
   // repeated abscissas); a few are plain random and not ascending at all.
   task automatic load_table(int n);
      int     i;
      longint step_cap, x;
      if ($urandom_range(0, 99) < 12) begin
         for (i = 0; i < n; i++) write_entry(6'(i), $urandom, pick_ordinate());
      end else begin
         case ($urandom_range(0, 3))
            0: step_cap = 4;
            1: step_cap = 1024;
            2: step_cap = 65536;
            default: step_cap = longint'(1) << 25;
         endcase
         x = pick_between(X_MIN, X_MAX - n * step_cap);
         for (i = 0; i < n; i++) begin
            write_entry(6'(i), 32'(x), pick_ordinate());
            if ($urandom_range(0, 19) != 0) x += longint'($urandom_range(1, int'(step_cap)));
         end
      end
   endtask

   // A write in the middle of a query stream. Inside the table it usually
   // keeps the order intact; otherwise it writes anything anywhere, which
   // also exercises entries beyond the count in use.
   task automatic write_mixed(int n);
      int                 index;
      logic signed [31:0] x, lower, upper;
      index = $urandom_range(0, TABLE_DEPTH - 1);
      if (index > 0 && index < n - 1 && $urandom_range(0, 9) < 7) begin
         lower = mirror.abscissa[index-1];
         upper = mirror.abscissa[index+1];
         if (longint'(upper) - longint'(lower) >= 2)
            x = 32'(pick_between(longint'(lower) + 1, longint'(upper) - 1));
         else
            x = mirror.abscissa[index];
      end else begin
         x = $urandom;
      end
      write_entry(6'(index), x, pick_ordinate());
   endtask

   function automatic int phase_setting(int phase);
      case (phase)
         0: return 64;
         1: return 127;
         2: return 3;
         3: return 65;
         4: return 1;
         5: return 16;
         6: return 2;
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   initial begin
      int i, n, phase, random_start, burst;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Two entries at the extremes of the number range with the reset count.
      // The span is the full 32-bit range, so the divisor is as large as it
      // gets and the products are at their largest.
      write_entry(6'd0, 32'sh80000000, 32'sh7FFFFFFF);
      write_entry(6'd1, 32'sh7FFFFFFF, 32'sh80000000);
      ask(32'sh80000000);
      ask(32'sh7FFFFFFF);
      ask(32'sh00000000);
      ask(32'shFFFFFFFF);
      ask(32'sh7FFFFFFE);
      ask(32'sh80000001);

      // A count of zero acts as two. The table is then descending, so one
      // query is clamped by the first entry and the other by the last.
      set_point_count(7'd0);
      write_entry(6'd0, 32'sh00010000, 32'sh00020000);
      write_entry(6'd1, 32'shFFFF0000, 32'sh00030000);
      ask(32'sh00000000);
      ask(32'sh00020000);

      // Five evenly spaced entries: exact hits found by the search, and
      // queries halfway inside two different pairs.
      set_point_count(7'd5);
      for (i = 0; i < 5; i++)
         write_entry(6'(i), 32'((i - 2) * 65536), 32'(i * 196608 - 100000));
      ask(32'sh00000000);
      ask(32'sh00008000);
      ask(32'sh00018000);
      ask(32'shFFFF0000);

      // Random phases: a new count, a fresh table, then a burst of queries
      // with writes mixed in. Several counts out of range come first.
      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         set_point_count(7'(phase_setting(phase)));
         pace_mode = $urandom_range(0, 2);
         n = mirror.effective_count();
         load_table(n);
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            if ($urandom_range(0, 99) < 80) ask(make_query(n));
            else write_mixed(n);
         end
         phase++;
      end

      drain_idle();
      if (mirror.mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* piecewise_linear_interp.f */
sv/pli_pkg.sv
sv/pli_table.sv
sv/pli_arith.sv
sv/piecewise_linear_interp.sv
test/tb_piecewise_linear_interp.sv
